// ===== rtl/clock_settings_button_menu_unit_macros.svh =====
// Assertion macros for the clock settings button menu block.
// No dependencies; included by the files that carry assertions.
`ifndef CLOCK_SETTINGS_BUTTON_MENU_UNIT_MACROS_SVH
`define CLOCK_SETTINGS_BUTTON_MENU_UNIT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CSBM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("csbm: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define CSBM_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("csbm: next-cycle check failed");

`endif

// ===== rtl/csbm_pkg.sv =====
// Types, constants and helper functions of the clock settings button menu.
// No dependencies; used by the interfaces, csbm_next and the top level.
package csbm_pkg;

  typedef enum logic [1:0] {
    BTN_UP     = 2'd0,
    BTN_DOWN   = 2'd1,
    BTN_SELECT = 2'd2
  } btn_e;

  typedef enum logic [7:0] {
    MODE_NORMAL   = 8'b0000_0001,
    MODE_MENU     = 8'b0000_0010,
    MODE_HOURS    = 8'b0000_0100,
    MODE_MINUTES  = 8'b0000_1000,
    MODE_DISPLAY  = 8'b0001_0000,
    MODE_COLOUR   = 8'b0010_0000,
    MODE_INTERVAL = 8'b0100_0000,
    MODE_SERIAL   = 8'b1000_0000
  } mode_e;

  // Mode codes as they appear on the result channel.
  localparam logic [2:0] CODE_NORMAL   = 3'd0;
  localparam logic [2:0] CODE_MENU     = 3'd1;
  localparam logic [2:0] CODE_HOURS    = 3'd2;
  localparam logic [2:0] CODE_MINUTES  = 3'd3;
  localparam logic [2:0] CODE_DISPLAY  = 3'd4;
  localparam logic [2:0] CODE_COLOUR   = 3'd5;
  localparam logic [2:0] CODE_INTERVAL = 3'd6;
  localparam logic [2:0] CODE_SERIAL   = 3'd7;

  // Main menu entries.
  localparam logic [2:0] MENU_TIME     = 3'd0;
  localparam logic [2:0] MENU_DISPLAY  = 3'd1;
  localparam logic [2:0] MENU_COLOUR   = 3'd2;
  localparam logic [2:0] MENU_INTERVAL = 3'd3;
  localparam logic [2:0] MENU_TOP      = 3'd4;

  localparam logic [4:0] HOURS_TOP     = 5'd23;
  localparam logic [5:0] MINUTES_TOP   = 6'd59;
  localparam logic [1:0] COLOUR_TOP    = 2'd2;
  localparam logic [6:0] INTERVAL_TOP  = 7'd99;
  localparam logic [6:0] INTERVAL_MIN  = 7'd1;
  localparam logic [6:0] INTERVAL_INIT = 7'd5;

  typedef struct packed {
    mode_e      mode;
    logic [2:0] menu_pos;
    logic [4:0] hours;
    logic [5:0] minutes;
    logic       display;
    logic [1:0] colour;
    logic       report;
    logic [6:0] interval;
  } menu_state_t;

  typedef struct packed {
    logic set_time;
    logic save;
  } strobe_t;

  // Step v within 0..top, wrapping at both ends.
  function automatic logic [6:0] wrap_step(logic [6:0] v, logic [6:0] top, logic up);
    logic [6:0] r;
    if (up) begin
      r = (v >= top) ? 7'd0 : v + 7'd1;
    end else begin
      r = (v == 7'd0 || v > top) ? top : v - 7'd1;
    end
    return r;
  endfunction

  function automatic logic [2:0] mode_code(mode_e m);
    logic [2:0] c;
    case (m)
      MODE_NORMAL:   c = CODE_NORMAL;
      MODE_MENU:     c = CODE_MENU;
      MODE_HOURS:    c = CODE_HOURS;
      MODE_MINUTES:  c = CODE_MINUTES;
      MODE_DISPLAY:  c = CODE_DISPLAY;
      MODE_COLOUR:   c = CODE_COLOUR;
      MODE_INTERVAL: c = CODE_INTERVAL;
      MODE_SERIAL:   c = CODE_SERIAL;
      default:       c = CODE_NORMAL;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/csbm_if.sv =====
// Valid/ready channel interfaces for button presses and menu results.
// Depends on csbm_pkg.
interface csbm_in_if import csbm_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [4:0] now_hours;
  logic [5:0] now_minutes;

  modport source (output valid, func, now_hours, now_minutes, input ready);
  modport sink   (input valid, func, now_hours, now_minutes, output ready);
endinterface

interface csbm_out_if import csbm_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [2:0] mode;
  logic [2:0] menu_item;
  logic [4:0] edit_hours;
  logic [5:0] edit_minutes;
  logic       display_on;
  logic [1:0] led_colour;
  logic       report_on;
  logic [6:0] report_interval;
  logic       set_time_strobe;
  logic       save_strobe;
  logic       menu_active;

  modport source (output valid, mode, menu_item, edit_hours, edit_minutes, display_on,
                  led_colour, report_on, report_interval, set_time_strobe,
                  save_strobe, menu_active, input ready);
  modport sink   (input valid, mode, menu_item, edit_hours, edit_minutes, display_on,
                  led_colour, report_on, report_interval, set_time_strobe,
                  save_strobe, menu_active, output ready);
endinterface

// ===== rtl/csbm_next.sv =====
// Next-state logic of the menu: one button press applied to the menu state.
// Depends on csbm_pkg.
module csbm_next import csbm_pkg::*; (
  input  menu_state_t state_i,
  input  logic [1:0]  func_i,
  input  logic [4:0]  now_hours_i,
  input  logic [5:0]  now_minutes_i,
  output menu_state_t state_o,
  output strobe_t     strobe_o
);

  logic up, dn, sel;

  assign up  = (func_i == BTN_UP);
  assign dn  = (func_i == BTN_DOWN);
  assign sel = (func_i == BTN_SELECT);

  always_comb begin
    state_o  = state_i;
    strobe_o = '0;
    case (state_i.mode)
      MODE_NORMAL: begin
        if (sel) begin
          state_o.mode     = MODE_MENU;
          state_o.menu_pos = MENU_TIME;
        end
      end
      MODE_MENU: begin
        // down moves forward through the list
        if (up || dn) begin
          state_o.menu_pos = 3'(wrap_step({4'd0, state_i.menu_pos}, {4'd0, MENU_TOP}, dn));
        end else if (sel) begin
          case (state_i.menu_pos)
            MENU_TIME: begin
              state_o.hours   = (now_hours_i > HOURS_TOP) ? HOURS_TOP : now_hours_i;
              state_o.minutes = (now_minutes_i > MINUTES_TOP) ? MINUTES_TOP : now_minutes_i;
              state_o.mode    = MODE_HOURS;
            end
            MENU_DISPLAY:  state_o.mode = MODE_DISPLAY;
            MENU_COLOUR:   state_o.mode = MODE_COLOUR;
            MENU_INTERVAL: state_o.mode = MODE_INTERVAL;
            default:       state_o.mode = MODE_SERIAL;
          endcase
        end
      end
      MODE_HOURS: begin
        if (up || dn) begin
          state_o.hours = 5'(wrap_step({2'd0, state_i.hours}, {2'd0, HOURS_TOP}, up));
        end else if (sel) begin
          state_o.mode = MODE_MINUTES;
        end
      end
      MODE_MINUTES: begin
        if (up || dn) begin
          state_o.minutes = 6'(wrap_step({1'b0, state_i.minutes}, {1'b0, MINUTES_TOP}, up));
        end else if (sel) begin
          strobe_o.set_time = 1'b1;
          state_o.mode      = MODE_NORMAL;
        end
      end
      MODE_DISPLAY: begin
        if (up || dn) begin
          state_o.display = ~state_i.display;
        end else if (sel) begin
          strobe_o.save = 1'b1;
          state_o.mode  = MODE_NORMAL;
        end
      end
      MODE_COLOUR: begin
        if (up || dn) begin
          state_o.colour = 2'(wrap_step({5'd0, state_i.colour}, {5'd0, COLOUR_TOP}, up));
        end else if (sel) begin
          strobe_o.save = 1'b1;
          state_o.mode  = MODE_NORMAL;
        end
      end
      MODE_INTERVAL: begin
        // range is 1..99, not 0..top
        if (up) begin
          state_o.interval = (state_i.interval >= INTERVAL_TOP) ? INTERVAL_MIN
                                                                : state_i.interval + 7'd1;
        end else if (dn) begin
          state_o.interval = (state_i.interval <= INTERVAL_MIN ||
                              state_i.interval > INTERVAL_TOP) ? INTERVAL_TOP
                                                               : state_i.interval - 7'd1;
        end else if (sel) begin
          strobe_o.save = 1'b1;
          state_o.mode  = MODE_NORMAL;
        end
      end
      MODE_SERIAL: begin
        if (up || dn) begin
          state_o.report = ~state_i.report;
        end else if (sel) begin
          strobe_o.save = 1'b1;
          state_o.mode  = MODE_NORMAL;
        end
      end
      default: begin
        state_o = state_i;
      end
    endcase
  end

endmodule

// ===== rtl/clock_settings_button_menu_unit.sv =====
// Clock settings button menu: press channel in, menu result channel out.
// Sinks one press per transaction; each press yields one result transaction.
// Channels are valid/ready: in_i carries func (0 up, 1 down, 2 select) with
// the current clock hours and minutes; out_o carries the menu state after the
// press plus the set-time and save strobes.
// The result of an accepted press is captured in the result register on acceptance.
// Throughput: one press per cycle while the receiver takes each result; the next-state
// logic sits between the menu state registers and a single result register.
// in_i.ready is high while the result register is empty or being drained in
// the same cycle, so a stalled receiver holds the result and stops presses
// after one; nothing is dropped.
// Reset: normal mode, menu entry 0, edit values 0, display and report on,
// colour 0, interval 5 s, result register empty.
// Depends on csbm_pkg, csbm_if.sv, csbm_next and the assertion macro header.
`include "clock_settings_button_menu_unit_macros.svh"

module clock_settings_button_menu_unit import csbm_pkg::*; (
  input  logic          clk_i,
  input  logic          rst_ni,
  csbm_in_if.sink       in_i,
  csbm_out_if.source    out_o
);

  menu_state_t state_q, state_d;
  strobe_t     strobe;
  logic        out_valid_q;
  logic        accept;

  typedef struct packed {
    logic [2:0] mode;
    logic [2:0] menu_item;
    logic [4:0] edit_hours;
    logic [5:0] edit_minutes;
    logic       display_on;
    logic [1:0] led_colour;
    logic       report_on;
    logic [6:0] report_interval;
    logic       set_time_strobe;
    logic       save_strobe;
    logic       menu_active;
  } result_t;

  result_t out_q, out_d;

  csbm_next u_next (
    .state_i       (state_q),
    .func_i        (in_i.func),
    .now_hours_i   (in_i.now_hours),
    .now_minutes_i (in_i.now_minutes),
    .state_o       (state_d),
    .strobe_o      (strobe)
  );

  assign in_i.ready = ~out_valid_q | out_o.ready;
  assign accept     = in_i.valid & in_i.ready;

  always_comb begin
    out_d.mode            = mode_code(state_d.mode);
    out_d.menu_item       = state_d.menu_pos;
    out_d.edit_hours      = state_d.hours;
    out_d.edit_minutes    = state_d.minutes;
    out_d.display_on      = state_d.display;
    out_d.led_colour      = state_d.colour;
    out_d.report_on       = state_d.report;
    out_d.report_interval = state_d.interval;
    out_d.set_time_strobe = strobe.set_time;
    out_d.save_strobe     = strobe.save;
    out_d.menu_active     = (state_d.mode != MODE_NORMAL);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q.mode     <= MODE_NORMAL;
      state_q.menu_pos <= MENU_TIME;
      state_q.hours    <= '0;
      state_q.minutes  <= '0;
      state_q.display  <= 1'b1;
      state_q.colour   <= '0;
      state_q.report   <= 1'b1;
      state_q.interval <= INTERVAL_INIT;
      out_valid_q      <= 1'b0;
    end else begin
      if (accept) begin
        state_q <= state_d;
      end
      if (accept) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q <= out_d;
    end
  end

  assign out_o.valid           = out_valid_q;
  assign out_o.mode            = out_q.mode;
  assign out_o.menu_item       = out_q.menu_item;
  assign out_o.edit_hours      = out_q.edit_hours;
  assign out_o.edit_minutes    = out_q.edit_minutes;
  assign out_o.display_on      = out_q.display_on;
  assign out_o.led_colour      = out_q.led_colour;
  assign out_o.report_on       = out_q.report_on;
  assign out_o.report_interval = out_q.report_interval;
  assign out_o.set_time_strobe = out_q.set_time_strobe;
  assign out_o.save_strobe     = out_q.save_strobe;
  assign out_o.menu_active     = out_q.menu_active;

  `CSBM_ASSERT_IMP(a_mode_onehot, clk_i, rst_ni, 1'b1, $onehot(state_q.mode))
  `CSBM_ASSERT_IMP(a_interval_range, clk_i, rst_ni, 1'b1, (state_q.interval >= INTERVAL_MIN && state_q.interval <= INTERVAL_TOP))
  `CSBM_ASSERT_IMP(a_strobe_exit, clk_i, rst_ni, out_valid_q && (out_q.set_time_strobe || out_q.save_strobe), (out_q.mode == CODE_NORMAL) && !(out_q.set_time_strobe && out_q.save_strobe))
  `CSBM_ASSERT_NXT(a_result_follows, clk_i, rst_ni, accept, out_valid_q && (out_q.mode == mode_code(state_q.mode)))

endmodule

// ===== sim/tb_clock_settings_button_menu_unit.sv =====
// Self-checking testbench for clock_settings_button_menu_unit: drives button presses
// over the valid/ready press channel and checks every menu result against a predictor.
// Depends on csbm_pkg, csbm_if.sv and the RTL of the block.
module tb_clock_settings_button_menu_unit import csbm_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] BTN_UNUSED     = 2'd3;
  localparam int         RANDOM_PRESSES = 1250;
  localparam int         HOLD_CYCLES    = 80;
  localparam int         QUIET_LIMIT    = 1000;
  localparam int         SETTLE_CYCLES  = 4;

  typedef struct packed {
    logic [2:0] mode;
    logic [2:0] menu_item;
    logic [4:0] edit_hours;
    logic [5:0] edit_minutes;
    logic       display_on;
    logic [1:0] led_colour;
    logic       report_on;
    logic [6:0] report_interval;
    logic       set_time_strobe;
    logic       save_strobe;
    logic       menu_active;
  } menu_view_t;

  // Tracks the menu state press by press and queues the view each press should produce.
  class menu_scoreboard;
    logic [2:0] mode_now;
    logic [2:0] entry_now;
    logic [4:0] hours_edit;
    logic [5:0] minutes_edit;
    logic       disp_on;
    logic [1:0] colour_sel;
    logic       report_en;
    logic [6:0] interval_sec;
    menu_view_t predicted_views[$];
    int         errors;

    function new();
      mode_now     = CODE_NORMAL;
      entry_now    = MENU_TIME;
      hours_edit   = '0;
      minutes_edit = '0;
      disp_on      = 1'b1;
      colour_sel   = 2'd0;
      report_en    = 1'b1;
      interval_sec = INTERVAL_INIT;
      errors       = 0;
    endfunction

    function logic [6:0] wrap_inc(logic [6:0] v, logic [6:0] top);
      return (v >= top) ? 7'd0 : v + 7'd1;
    endfunction

    function logic [6:0] wrap_dec(logic [6:0] v, logic [6:0] top);
      return (v == 7'd0 || v > top) ? top : v - 7'd1;
    endfunction

    function int pending();
      return predicted_views.size();
    endfunction

    function void note_press(logic [1:0] func, logic [4:0] now_h, logic [5:0] now_m);
      menu_view_t view;
      logic is_up, is_dn, is_sel, set_time, save;
      is_up    = (func == BTN_UP);
      is_dn    = (func == BTN_DOWN);
      is_sel   = (func == BTN_SELECT);
      set_time = 1'b0;
      save     = 1'b0;
      case (mode_now)
        CODE_NORMAL: begin
          if (is_sel) begin
            mode_now  = CODE_MENU;
            entry_now = MENU_TIME;
          end
        end
        CODE_MENU: begin
          // down walks forward through the entries, up walks back
          if (is_dn) entry_now = 3'(wrap_inc(7'(entry_now), 7'(MENU_TOP)));
          else if (is_up) entry_now = 3'(wrap_dec(7'(entry_now), 7'(MENU_TOP)));
          else if (is_sel) begin
            case (entry_now)
              MENU_TIME: begin
                hours_edit   = (now_h > HOURS_TOP) ? HOURS_TOP : now_h;
                minutes_edit = (now_m > MINUTES_TOP) ? MINUTES_TOP : now_m;
                mode_now     = CODE_HOURS;
              end
              MENU_DISPLAY:  mode_now = CODE_DISPLAY;
              MENU_COLOUR:   mode_now = CODE_COLOUR;
              MENU_INTERVAL: mode_now = CODE_INTERVAL;
              default:       mode_now = CODE_SERIAL;
            endcase
          end
        end
        CODE_HOURS: begin
          if (is_up) hours_edit = 5'(wrap_inc(7'(hours_edit), 7'(HOURS_TOP)));
          else if (is_dn) hours_edit = 5'(wrap_dec(7'(hours_edit), 7'(HOURS_TOP)));
          else if (is_sel) mode_now = CODE_MINUTES;
        end
        CODE_MINUTES: begin
          if (is_up) minutes_edit = 6'(wrap_inc(7'(minutes_edit), 7'(MINUTES_TOP)));
          else if (is_dn) minutes_edit = 6'(wrap_dec(7'(minutes_edit), 7'(MINUTES_TOP)));
          else if (is_sel) begin
            set_time = 1'b1;
            mode_now = CODE_NORMAL;
          end
        end
        CODE_DISPLAY: begin
          if (is_up || is_dn) disp_on = ~disp_on;
          else if (is_sel) begin
            save     = 1'b1;
            mode_now = CODE_NORMAL;
          end
        end
        CODE_COLOUR: begin
          if (is_up) colour_sel = 2'(wrap_inc(7'(colour_sel), 7'(COLOUR_TOP)));
          else if (is_dn) colour_sel = 2'(wrap_dec(7'(colour_sel), 7'(COLOUR_TOP)));
          else if (is_sel) begin
            save     = 1'b1;
            mode_now = CODE_NORMAL;
          end
        end
        CODE_INTERVAL: begin
          // interval runs 1..99, so it wraps to 1 rather than 0
          if (is_up) interval_sec = (interval_sec >= INTERVAL_TOP) ? INTERVAL_MIN
                                                                    : interval_sec + 7'd1;
          else if (is_dn) interval_sec = (interval_sec <= INTERVAL_MIN ||
                                          interval_sec > INTERVAL_TOP) ? INTERVAL_TOP
                                                                        : interval_sec - 7'd1;
          else if (is_sel) begin
            save     = 1'b1;
            mode_now = CODE_NORMAL;
          end
        end
        default: begin
          if (is_up || is_dn) report_en = ~report_en;
          else if (is_sel) begin
            save     = 1'b1;
            mode_now = CODE_NORMAL;
          end
        end
      endcase
      view = '{mode_now, entry_now, hours_edit, minutes_edit, disp_on, colour_sel,
               report_en, interval_sec, set_time, save, mode_now != CODE_NORMAL};
      predicted_views.push_back(view);
    endfunction

    function void compare_field(string field, logic [6:0] want, logic [6:0] got);
      if (got !== want) begin
        $error("%s: expected %0d, got %0d", field, want, got);
        errors++;
      end
    endfunction

    function void check_result(menu_view_t got);
      menu_view_t want;
      if (predicted_views.size() == 0) begin
        $error("result transaction with no press waiting for it");
        errors++;
        return;
      end
      want = predicted_views.pop_front();
      compare_field("mode", 7'(want.mode), 7'(got.mode));
      compare_field("menu_item", 7'(want.menu_item), 7'(got.menu_item));
      compare_field("edit_hours", 7'(want.edit_hours), 7'(got.edit_hours));
      compare_field("edit_minutes", 7'(want.edit_minutes), 7'(got.edit_minutes));
      compare_field("display_on", 7'(want.display_on), 7'(got.display_on));
      compare_field("led_colour", 7'(want.led_colour), 7'(got.led_colour));
      compare_field("report_on", 7'(want.report_on), 7'(got.report_on));
      compare_field("report_interval", want.report_interval, got.report_interval);
      compare_field("set_time_strobe", 7'(want.set_time_strobe), 7'(got.set_time_strobe));
      compare_field("save_strobe", 7'(want.save_strobe), 7'(got.save_strobe));
      compare_field("menu_active", 7'(want.menu_active), 7'(got.menu_active));
    endfunction
  endclass

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  bit   steady = 1'b0;        // both sides stop idling while set
  bit   hold_request = 1'b0;  // asks the receiver for a long hold-off
  int   quiet_cycles = 0;
  menu_scoreboard board;

  csbm_in_if  press_if ();
  csbm_out_if result_if ();

  clock_settings_button_menu_unit uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (press_if),
    .out_o  (result_if)
  );

  always #1 clk_i = ~clk_i;

  // Called at a rising edge; returns at the edge where the press transaction completes.
  // valid stays high afterwards so back-to-back presses need no extra assignment.
  task automatic send_press(input logic [1:0] f, input logic [4:0] h, input logic [5:0] m);
    while (!steady && $urandom_range(0, 99) < 36) begin
      press_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    press_if.valid       <= 1'b1;
    press_if.func        <= f;
    press_if.now_hours   <= h;
    press_if.now_minutes <= m;
    do @(posedge clk_i); while (!press_if.ready);
    board.note_press(f, h, m);
  endtask

  task automatic wait_drained();
    press_if.valid <= 1'b0;
    do @(posedge clk_i); while (board.pending() != 0);
  endtask

  // Mostly well-formed menu sessions, with some noise mixed in.
  function automatic logic [1:0] pick_func(logic [2:0] mode, bit lean_up);
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 6) return 2'($urandom_range(0, 3));
    case (mode)
      CODE_NORMAL:   return (roll < 85) ? BTN_SELECT
                                        : ($urandom_range(0, 1) ? BTN_DOWN : BTN_UP);
      CODE_MENU:     return (roll < 30) ? BTN_SELECT
                                        : ($urandom_range(0, 1) ? BTN_DOWN : BTN_UP);
      CODE_INTERVAL: begin
        // long sessions so the interval wraps at both ends
        if (roll < 9) return BTN_SELECT;
      end
      default: begin
        if (roll < 20) return BTN_SELECT;
      end
    endcase
    if ($urandom_range(0, 99) < 85) return lean_up ? BTN_UP : BTN_DOWN;
    return lean_up ? BTN_DOWN : BTN_UP;
  endfunction

  // Receiver: checks each result transaction and drives ready.
  initial begin
    menu_view_t got;
    int hold_left;
    hold_left = 0;
    result_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (result_if.valid && result_if.ready) begin
        got = '{result_if.mode, result_if.menu_item, result_if.edit_hours,
                result_if.edit_minutes, result_if.display_on, result_if.led_colour,
                result_if.report_on, result_if.report_interval, result_if.set_time_strobe,
                result_if.save_strobe, result_if.menu_active};
        board.check_result(got);
      end
      if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        result_if.ready <= 1'b0;
      end else begin
        result_if.ready <= steady || ($urandom_range(0, 99) >= 36);
      end
    end
  end

  // Watchdog: ends the run when no transaction moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (press_if.valid && press_if.ready) ||
        (result_if.valid && result_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("clock_settings_button_menu_unit verification failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    logic [1:0] plan [26];
    logic [1:0] f;
    bit lean_up;
    int sent;
    int counted;
    board = new();
    press_if.valid       = 1'b0;
    press_if.func        = BTN_UP;
    press_if.now_hours   = '0;
    press_if.now_minutes = '0;
    plan = '{BTN_UNUSED, BTN_UP, BTN_DOWN, BTN_SELECT, BTN_UP, BTN_DOWN, BTN_SELECT,
             BTN_UP, BTN_DOWN, BTN_UNUSED, BTN_SELECT, BTN_UP, BTN_DOWN, BTN_SELECT,
             BTN_SELECT, BTN_DOWN, BTN_SELECT, BTN_UP, BTN_SELECT, BTN_SELECT,
             BTN_DOWN, BTN_DOWN, BTN_SELECT, BTN_DOWN, BTN_UP, BTN_SELECT};
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: ignored presses, menu wrap, clamped clock copy, hour and minute
    // wrap, set-time, display toggle, colour wrap and the save strobe.
    for (int i = 0; i < 26; i++) begin
      if (i == 6) send_press(plan[i], 5'd31, 6'd63);
      else send_press(plan[i], 5'($urandom_range(0, 31)), 6'($urandom_range(0, 63)));
    end
    wait_drained();

    sent    = 0;
    counted = 0;
    lean_up = 1'b0;
    while (counted < RANDOM_PRESSES) begin
      if (board.mode_now == CODE_NORMAL) lean_up = 1'($urandom_range(0, 1));
      f = pick_func(board.mode_now, lean_up);
      if (!(f == BTN_UNUSED || (board.mode_now == CODE_NORMAL && f != BTN_SELECT)))
        counted++;
      sent++;
      if (sent == 350) hold_request = 1'b1;
      if (sent == 800) steady = 1'b1;
      if (sent == 1050) steady = 1'b0;
      if (sent == 700) wait_drained();
      send_press(f, 5'($urandom_range(0, 31)), 6'($urandom_range(0, 63)));
    end

    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (board.errors == 0 && board.pending() == 0) begin
      $display("clock_settings_button_menu_unit verification clean");
    end else begin
      $display("clock_settings_button_menu_unit verification failed");
    end
    $finish;
  end

endmodule
